// ----- hdl/rac_pkg.sv -----
package rac_pkg;

    localparam int SAMPLE_PORT_BITS = 16;
    localparam int LAG_PORT_BITS    = 8;
    localparam int SUM_BITS         = 64;
    localparam int COUNT_BITS       = 32;

    localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;    // zero one accumulator, step the lag counter down
        logic store_sample;  // write incoming sample to the ring (history not full)
        logic walk_start;    // latch sample, load slot and lag counters
        logic walk_step;     // issue one lag: ring and accumulator reads
        logic walk_finish;   // retire latched sample into the ring, bump counts
        logic read_start;    // latch the clamped read lag
        logic out_load;      // load the result register
    } rac_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic lag_last;
        logic pipe_busy;
        logic out_free;
        logic history_full;
    } rac_status_t;

endpackage

// ----- hdl/rac_ram.sv -----
module rac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/rac_ctrl.sv -----
module rac_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  rac_pkg::rac_status_t status,
    output rac_pkg::rac_cmd_t    cmd
);
    import rac_pkg::*;

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_WALK    = 3'd2;
    localparam logic [2:0] ST_DRAIN   = 3'd3;
    localparam logic [2:0] ST_RD_ADDR = 3'd4;
    localparam logic [2:0] ST_RD_DATA = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.lag_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_PUSH) begin
                        if (status.history_full) begin
                            cmd.walk_start = 1'b1;
                            state_next     = ST_WALK;
                        end else begin
                            cmd.store_sample = 1'b1;
                        end
                    end else begin
                        cmd.read_start = 1'b1;
                        state_next     = ST_RD_ADDR;
                    end
                end
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (status.lag_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last accumulator write before retiring the sample
                if (!status.pipe_busy) begin
                    cmd.walk_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_RD_ADDR: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                // hold until the result register is free
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/rac_datapath.sv -----
module rac_datapath #(
    parameter int HISTORY_LENGTH = 128,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  rac_pkg::rac_cmd_t                             cmd,
    output rac_pkg::rac_status_t                          status,
    input  logic signed [rac_pkg::SAMPLE_PORT_BITS-1:0]   sample_value,
    input  logic [rac_pkg::LAG_PORT_BITS-1:0]             lag_select,
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output logic [rac_pkg::LAG_PORT_BITS-1:0]             m_lag_echo,
    output logic signed [rac_pkg::SUM_BITS-1:0]           m_lag_sum,
    output logic [rac_pkg::COUNT_BITS-1:0]                m_contrib_count,
    output logic                                          m_history_full
);
    import rac_pkg::*;

    localparam int PW        = $clog2(HISTORY_LENGTH);
    localparam int LW        = $clog2(HISTORY_LENGTH + 1);
    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam logic [PW-1:0] PTR_LAST = PW'(HISTORY_LENGTH - 1);
    localparam logic [LW-1:0] LAG_MAX  = LW'(HISTORY_LENGTH);

    // take the low SAMPLE_BITS of the zero-extended field as two's complement
    logic [31:0]                  raw_wide;
    logic signed [SAMPLE_BITS-1:0] port_sample;
    logic [31:0]                  lag_wide;
    logic [31:0]                  echo_wide;

    assign raw_wide    = {{(32-SAMPLE_PORT_BITS){1'b0}}, sample_value};
    assign port_sample = raw_wide[SAMPLE_BITS-1:0];
    assign lag_wide    = (32'(lag_select) > 32'(HISTORY_LENGTH)) ?
                         32'(HISTORY_LENGTH) : 32'(lag_select);

    // control state
    logic [PW-1:0]         ptr_reg, ptr_next;
    logic [PW-1:0]         slot_reg, slot_next;
    logic [LW-1:0]         lag_cnt_reg, lag_cnt_next;
    logic [COUNT_BITS-1:0] seen_reg, seen_next;
    logic [COUNT_BITS-1:0] contrib_reg, contrib_next;
    logic                  v1_reg, v2_reg;
    logic                  m_valid_reg, m_valid_next;

    // payload
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [LW-1:0]                 rd_lag_reg;
    logic [LW-1:0]                 lag1_reg, lag2_reg;
    logic signed [PROD_BITS-1:0]   prod_reg, prod_next;
    logic signed [SUM_BITS-1:0]    accd_reg;
    logic [LAG_PORT_BITS-1:0]      out_lag_reg;
    logic signed [SUM_BITS-1:0]    out_sum_reg;
    logic [COUNT_BITS-1:0]         out_count_reg;
    logic                          out_full_reg;

    logic                          history_full;
    logic                          ring_we;
    logic [SAMPLE_BITS-1:0]        ring_wdata;
    logic [SAMPLE_BITS-1:0]        ring_rdata;
    logic signed [SAMPLE_BITS-1:0] operand;
    logic                          acc_we;
    logic [LW-1:0]                 acc_waddr;
    logic [SUM_BITS-1:0]           acc_wdata;
    logic [LW-1:0]                 acc_raddr;
    logic [SUM_BITS-1:0]           acc_rdata;
    logic signed [SUM_BITS-1:0]    prod_ext;
    logic signed [SUM_BITS-1:0]    sum_raw;
    logic signed [SUM_BITS-1:0]    sum_sat;
    logic                          sum_ovf;

    assign history_full = (seen_reg >= COUNT_BITS'(HISTORY_LENGTH));

    assign status.lag_last     = (lag_cnt_reg == '0);
    assign status.pipe_busy    = v1_reg | v2_reg;
    assign status.out_free     = !m_valid_reg || m_ready;
    assign status.history_full = history_full;

    // sample ring
    assign ring_we    = cmd.store_sample | cmd.walk_finish;
    assign ring_wdata = cmd.walk_finish ? x_reg : port_sample;

    rac_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (HISTORY_LENGTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ptr_reg),
        .wdata (ring_wdata),
        .raddr (slot_reg),
        .rdata (ring_rdata)
    );

    // lag accumulators
    assign acc_we    = cmd.clear_step | v2_reg;
    assign acc_waddr = cmd.clear_step ? lag_cnt_reg : lag2_reg;
    assign acc_wdata = cmd.clear_step ? '0 : sum_sat;
    assign acc_raddr = cmd.walk_step ? lag_cnt_reg : rd_lag_reg;

    rac_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (HISTORY_LENGTH + 1)
    ) u_acc (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // lag zero multiplies the new sample by itself
    assign operand   = (lag1_reg == '0) ? x_reg : $signed(ring_rdata);
    assign prod_next = PROD_BITS'(x_reg) * PROD_BITS'(operand);

    assign prod_ext = {{(SUM_BITS-PROD_BITS){prod_reg[PROD_BITS-1]}}, prod_reg};
    assign sum_raw  = accd_reg + prod_ext;
    assign sum_ovf  = (accd_reg[SUM_BITS-1] == prod_ext[SUM_BITS-1]) &&
                      (sum_raw[SUM_BITS-1] != accd_reg[SUM_BITS-1]);
    assign sum_sat  = !sum_ovf ? sum_raw :
                      (accd_reg[SUM_BITS-1] ? SUM_MIN : SUM_MAX);

    always_comb begin
        ptr_next     = ptr_reg;
        slot_next    = slot_reg;
        lag_cnt_next = lag_cnt_reg;
        seen_next    = seen_reg;
        contrib_next = contrib_reg;
        if (cmd.store_sample || cmd.walk_finish) begin
            ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
            if (seen_reg != '1) begin
                seen_next = seen_reg + 1'b1;
            end
        end
        if (cmd.walk_finish && contrib_reg != '1) begin
            contrib_next = contrib_reg + 1'b1;
        end
        if (cmd.walk_start) begin
            slot_next    = ptr_reg;
            lag_cnt_next = LAG_MAX;
        end
        if (cmd.walk_step) begin
            slot_next    = (slot_reg == PTR_LAST) ? '0 : slot_reg + 1'b1;
            lag_cnt_next = lag_cnt_reg - 1'b1;
        end
        if (cmd.clear_step) begin
            lag_cnt_next = lag_cnt_reg - 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            slot_reg    <= '0;
            lag_cnt_reg <= LAG_MAX;
            seen_reg    <= '0;
            contrib_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            ptr_reg     <= ptr_next;
            slot_reg    <= slot_next;
            lag_cnt_reg <= lag_cnt_next;
            seen_reg    <= seen_next;
            contrib_reg <= contrib_next;
            v1_reg      <= cmd.walk_step;
            v2_reg      <= v1_reg;
            m_valid_reg <= m_valid_next;
        end
    end

    assign echo_wide = 32'(rd_lag_reg);

    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            x_reg <= port_sample;
        end
        if (cmd.read_start) begin
            rd_lag_reg <= lag_wide[LW-1:0];
        end
        lag1_reg <= lag_cnt_reg;
        lag2_reg <= lag1_reg;
        prod_reg <= prod_next;
        accd_reg <= $signed(acc_rdata);
        if (cmd.out_load) begin
            out_lag_reg   <= echo_wide[LAG_PORT_BITS-1:0];
            out_sum_reg   <= $signed(acc_rdata);
            out_count_reg <= contrib_reg;
            out_full_reg  <= history_full;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_lag_echo      = out_lag_reg;
    assign m_lag_sum       = out_sum_reg;
    assign m_contrib_count = out_count_reg;
    assign m_history_full  = out_full_reg;

endmodule

// ----- hdl/running_autocorrelation_top.sv -----
// Running autocorrelation of one pixel's sample stream. A push (req_type 0)
// stores a signed sample in a HISTORY_LENGTH-deep ring; once the ring has
// filled, each push adds x[n]*x[n-lag] into a saturating 64-bit sum for every
// lag 0..HISTORY_LENGTH. A read (req_type 1) returns one transaction with the
// sum at the requested lag (clamped to HISTORY_LENGTH), the saturating count
// of accumulating pushes and the history-full flag; software divides. A push
// before the ring is full only stores the sample; a push after it is full
// makes one multiplier walk the lags one per cycle through the accumulator
// RAM, and a read may wait for the result register to be free.
// After reset the block zeroes the accumulators for every lag and keeps
// s_ready low meanwhile. A push is taken while an earlier read result is
// still waiting on the m_ side.
module running_autocorrelation_top #(
    parameter int HISTORY_LENGTH = 128,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic                                        s_req_type,
    input  logic signed [rac_pkg::SAMPLE_PORT_BITS-1:0] s_sample_value,
    input  logic [rac_pkg::LAG_PORT_BITS-1:0]           s_lag_select,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic [rac_pkg::LAG_PORT_BITS-1:0]           m_lag_echo,
    output logic signed [rac_pkg::SUM_BITS-1:0]         m_lag_sum,
    output logic [rac_pkg::COUNT_BITS-1:0]              m_contrib_count,
    output logic                                        m_history_full
);
    import rac_pkg::*;

    rac_cmd_t    cmd;
    rac_status_t status;

    rac_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .status     (status),
        .cmd        (cmd)
    );

    rac_datapath #(
        .HISTORY_LENGTH (HISTORY_LENGTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .sample_value    (s_sample_value),
        .lag_select      (s_lag_select),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lag_echo      (m_lag_echo),
        .m_lag_sum       (m_lag_sum),
        .m_contrib_count (m_contrib_count),
        .m_history_full  (m_history_full)
    );

endmodule

// ----- test/tb_running_autocorrelation_top.sv -----
`timescale 1ns / 1ps

module tb_running_autocorrelation_top;

    import rac_pkg::*;

    localparam int HIST        = 128;
    localparam int SBITS       = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = HIST + 16;

    typedef struct {
        logic                               req;
        logic signed [SAMPLE_PORT_BITS-1:0] sample;
        logic [LAG_PORT_BITS-1:0]           lag;
    } corr_request_t;

    typedef struct {
        logic [LAG_PORT_BITS-1:0]    lag;
        logic signed [SUM_BITS-1:0]  sum;
        logic [COUNT_BITS-1:0]       count;
        logic                        full;
    } lag_report_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                               s_valid        = 1'b0;
    logic                               s_ready;
    logic                               s_req_type     = REQ_PUSH;
    logic signed [SAMPLE_PORT_BITS-1:0] s_sample_value = '0;
    logic [LAG_PORT_BITS-1:0]           s_lag_select   = '0;
    logic                               m_valid;
    logic                               m_ready        = 1'b0;
    logic [LAG_PORT_BITS-1:0]           m_lag_echo;
    logic signed [SUM_BITS-1:0]         m_lag_sum;
    logic [COUNT_BITS-1:0]              m_contrib_count;
    logic                               m_history_full;

    corr_request_t request_queue[$];
    lag_report_t   lag_reports[$];

    // predictor state
    logic signed [SBITS-1:0]      hist_ring [HIST];
    logic signed [SUM_BITS-1:0]   lag_sums  [HIST+1] = '{default: '0};
    logic [COUNT_BITS-1:0]        pushes_seen   = '0;
    logic [COUNT_BITS-1:0]        contrib_total = '0;
    int                           ring_wr       = 0;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_go        = 1'b0;
    logic hold_done      = 1'b0;
    int   hold_left      = 0;
    logic in_fire        = 1'b0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;

    running_autocorrelation_top #(
        .HISTORY_LENGTH(HIST),
        .SAMPLE_BITS   (SBITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_sample_value (s_sample_value),
        .s_lag_select   (s_lag_select),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lag_echo     (m_lag_echo),
        .m_lag_sum      (m_lag_sum),
        .m_contrib_count(m_contrib_count),
        .m_history_full (m_history_full)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic signed [SUM_BITS-1:0] sat_add64(
        input logic signed [SUM_BITS-1:0] a,
        input logic signed [SUM_BITS-1:0] b
    );
        logic signed [SUM_BITS-1:0] s;
        s = a + b;
        if (a[SUM_BITS-1] == b[SUM_BITS-1] && s[SUM_BITS-1] != a[SUM_BITS-1])
            return a[SUM_BITS-1] ? SUM_MIN : SUM_MAX;
        return s;
    endfunction

    task automatic autocorr_apply(input corr_request_t rq);
        logic signed [SBITS-1:0]    x;
        logic signed [SUM_BITS-1:0] prod;
        int                         slot;
        int                         lag;
        lag_report_t                rep;
        if (rq.req == REQ_PUSH) begin
            x = rq.sample[SBITS-1:0];
            if (pushes_seen >= HIST) begin
                // slot ring_wr + j holds the sample HIST - j pushes back
                for (int j = 0; j < HIST; j++) begin
                    slot = (ring_wr + j) % HIST;
                    prod = SUM_BITS'(x) * SUM_BITS'(hist_ring[slot]);
                    lag_sums[HIST-j] = sat_add64(lag_sums[HIST-j], prod);
                end
                prod = SUM_BITS'(x) * SUM_BITS'(x);
                lag_sums[0] = sat_add64(lag_sums[0], prod);
                if (contrib_total != '1)
                    contrib_total = contrib_total + 1;
            end
            hist_ring[ring_wr] = x;
            ring_wr = (ring_wr + 1) % HIST;
            if (pushes_seen != '1)
                pushes_seen = pushes_seen + 1;
        end else begin
            lag = (rq.lag > HIST) ? HIST : int'(rq.lag);
            rep.lag   = LAG_PORT_BITS'(lag);
            rep.sum   = lag_sums[lag];
            rep.count = contrib_total;
            rep.full  = (pushes_seen >= HIST);
            lag_reports.push_back(rep);
        end
    endtask

    // input acceptance and result checking
    always @(posedge aclk) begin
        lag_report_t want;
        in_fire <= s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (lag_reports.size() == 0) begin
                $display("%0t: unexpected result lag %0d sum %0d count %0d full %0d",
                         $time, m_lag_echo, m_lag_sum, m_contrib_count, m_history_full);
                mismatch_count++;
            end else begin
                want = lag_reports.pop_front();
                if (m_lag_echo !== want.lag) begin
                    $display("%0t: lag_echo expected %0d actual %0d",
                             $time, want.lag, m_lag_echo);
                    mismatch_count++;
                end
                if (m_lag_sum !== want.sum) begin
                    $display("%0t: lag_sum (lag %0d) expected %0d actual %0d",
                             $time, want.lag, want.sum, m_lag_sum);
                    mismatch_count++;
                end
                if (m_contrib_count !== want.count) begin
                    $display("%0t: contrib_count expected %0d actual %0d",
                             $time, want.count, m_contrib_count);
                    mismatch_count++;
                end
                if (m_history_full !== want.full) begin
                    $display("%0t: history_full expected %0d actual %0d",
                             $time, want.full, m_history_full);
                    mismatch_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready)
            autocorr_apply('{req: s_req_type, sample: s_sample_value, lag: s_lag_select});
    end

    // driver
    always @(negedge aclk) begin
        corr_request_t rq;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                rq = request_queue.pop_front();
                s_valid        <= 1'b1;
                s_req_type     <= rq.req;
                s_sample_value <= rq.sample;
                s_lag_select   <= rq.lag;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(negedge aclk) begin
        if (hold_go && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge aclk) begin
        m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_push(input logic signed [SAMPLE_PORT_BITS-1:0] v);
        request_queue.push_back('{req: REQ_PUSH, sample: v,
                                  lag: LAG_PORT_BITS'($urandom)});
    endtask

    task automatic add_read(input logic [LAG_PORT_BITS-1:0] l);
        request_queue.push_back('{req: REQ_READ,
                                  sample: SAMPLE_PORT_BITS'($urandom), lag: l});
    endtask

    task automatic add_random(input int n, input int read_pct);
        int r;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < read_pct) begin
                if ($urandom_range(19) == 0)
                    add_read(LAG_PORT_BITS'($urandom_range(255, HIST + 1)));
                else
                    add_read(LAG_PORT_BITS'($urandom_range(HIST)));
            end else begin
                r = $urandom_range(19);
                case (r)
                    0:       add_push(16'sh7fff);
                    1:       add_push(16'sh8000);
                    2:       add_push(16'sh0000);
                    3:       add_push(16'shffff);
                    default: add_push(SAMPLE_PORT_BITS'($urandom));
                endcase
            end
        end
    endtask

    task automatic wait_drain();
        while (request_queue.size() != 0 || s_valid || lag_reports.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // reads before the history fills, lag clamp, sample extremes
        add_read(8'd0);
        add_read(8'(HIST));
        add_read(8'(HIST + 1));
        add_read(8'd255);
        add_push(16'sh7fff);
        add_push(16'sh8000);
        add_push(16'sh0000);
        add_push(16'shffff);
        add_push(16'sh0001);
        add_read(8'd64);
        add_read(8'd1);
        wait_drain();

        // no idling; fill the history and keep going
        add_random(300, 20);
        wait_drain();

        send_idle_pct  = 69;
        recv_stall_pct = 0;
        add_random(280, 30);
        wait_drain();

        send_idle_pct  = 0;
        recv_stall_pct = 69;
        add_random(280, 30);
        wait_drain();

        send_idle_pct  = 29;
        recv_stall_pct = 29;
        add_random(280, 30);
        wait_drain();

        // hold the result side off while reads pile up on the input
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go        = 1'b1;
        add_random(60, 70);
        add_random(200, 30);
        wait_drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/rac_pkg.sv
hdl/rac_ram.sv
hdl/rac_ctrl.sv
hdl/rac_datapath.sv
hdl/running_autocorrelation_top.sv
test/tb_running_autocorrelation_top.sv
